// ===== hw/rtl/bbcq_pkg.sv =====
// Shared types and constants for the bounding box coordinate quantiser.
// Used by bbcq_box, bbcq_alu and the top level; depends on nothing else.
package bbcq_pkg;

	// Default sizes of the coordinate path and of the bucket count exponent.
	localparam int COORD_WIDTH_DEF = 32;
	localparam int MAX_BITS_DEF    = 24;

	// Fixed widths of the stream fields and of the configuration registers.
	localparam int VAL_W     = 32;
	localparam int NUM_AXES  = 3;
	localparam int BITS_W    = 5;
	localparam int REG_IDX_W = 2;

	localparam logic [BITS_W-1:0] BITS_RESET = 5'd8;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_X_BITS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_Y_BITS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_Z_BITS = 2'd2;

	// Item kinds carried in tuser.
	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_WIDEN   = 2'd1,
		KIND_QUANT   = 2'd2,
		KIND_DEQUANT = 2'd3
	} kind_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_STORE,
		ST_EMIT
	} seq_state_t;

	// Control word from the sequencer to the shared arithmetic unit.
	typedef struct packed {
		logic load;
		logic mode_div;
	} alu_ctl_t;

endpackage

// ===== hw/rtl/bbcq_box.sv =====
// Bounding box store: low and high corner per axis, set or widened by words.
// Depends on bbcq_pkg.
module bbcq_box #(
	parameter int COORD_WIDTH = bbcq_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  logic                          start,
	input  logic signed [COORD_WIDTH-1:0] coord [bbcq_pkg::NUM_AXES],
	output logic signed [COORD_WIDTH-1:0] low   [bbcq_pkg::NUM_AXES],
	output logic signed [COORD_WIDTH-1:0] high  [bbcq_pkg::NUM_AXES]
);
	import bbcq_pkg::*;

	logic signed [COORD_WIDTH-1:0] low_q  [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] high_q [NUM_AXES];

	// A start word sets both corners; a widen word moves each corner outward.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				low_q[a]  <= '0;
				high_q[a] <= '0;
			end
		end else if (upd) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				if (start) begin
					low_q[a]  <= coord[a];
					high_q[a] <= coord[a];
				end else begin
					if (coord[a] < low_q[a]) low_q[a] <= coord[a];
					if (coord[a] > high_q[a]) high_q[a] <= coord[a];
				end
			end
		end
	end

	assign low  = low_q;
	assign high = high_q;

endmodule

// ===== hw/rtl/bbcq_alu.sv =====
// Shared add/subtract unit that runs restoring division and shift-add
// multiplication one bit per cycle. Depends on bbcq_pkg.
module bbcq_alu #(
	parameter int COORD_WIDTH = bbcq_pkg::COORD_WIDTH_DEF,
	parameter int MAX_BITS    = bbcq_pkg::MAX_BITS_DEF,
	localparam int CNTW       = $clog2(MAX_BITS + 2)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bbcq_pkg::alu_ctl_t        ctl,
	input  logic [COORD_WIDTH-1:0]    range_in,
	input  logic [COORD_WIDTH-1:0]    acc_in,
	input  logic [MAX_BITS:0]         sh_in,
	input  logic [CNTW-1:0]           cnt_in,
	output logic                      busy,
	output logic [COORD_WIDTH-1:0]    acc,
	output logic [MAX_BITS:0]         sh
);
	import bbcq_pkg::*;

	localparam int AW = COORD_WIDTH + 2;

	logic [COORD_WIDTH:0]   acc_q;
	logic [MAX_BITS:0]      sh_q;
	logic [COORD_WIDTH-1:0] range_q;
	logic [CNTW-1:0]        cnt_q;
	logic                   div_q;

	logic [AW-1:0] opa;
	logic [AW-1:0] opb;
	logic [AW-1:0] sum;
	logic          fits;

	// One adder serves both modes: 2r - range for division, acc + range for
	// multiplication when the current multiplier bit is set.
	always_comb begin
		if (div_q) begin
			opa = {1'b0, acc_q[COORD_WIDTH-1:0], 1'b0};
			opb = ~{2'b00, range_q};
		end else begin
			opa = {1'b0, acc_q};
			opb = sh_q[0] ? {2'b00, range_q} : '0;
		end
		sum  = opa + opb + AW'(div_q);
		fits = ~sum[AW-1];
	end

	// Counter and mode are control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			div_q <= 1'b0;
		end else if (ctl.load) begin
			cnt_q <= cnt_in;
			div_q <= ctl.mode_div;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	// Datapath registers: remainder or partial product, quotient or multiplier.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q   <= {1'b0, acc_in};
			sh_q    <= sh_in;
			range_q <= range_in;
		end else if (cnt_q != '0) begin
			if (div_q) begin
				if (fits) acc_q <= sum[COORD_WIDTH:0];
				else acc_q <= {acc_q[COORD_WIDTH-1:0], 1'b0};
				sh_q <= {sh_q[MAX_BITS-1:0], fits};
			end else begin
				acc_q <= sum[AW-1:1];
				sh_q  <= {1'b0, sh_q[MAX_BITS:1]};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign acc  = acc_q[COORD_WIDTH-1:0];
	assign sh   = sh_q;

endmodule

// ===== hw/rtl/bounding_box_coordinate_quantiser_unit.sv =====
// Top level of the bounding box coordinate quantiser: stream ports,
// configuration registers, sequencer and output register.
// Depends on bbcq_pkg, bbcq_box and bbcq_alu.
// Sequence: start and widen words update the box when taken and give no result.
// Quantise and dequantise words run the axes in turn through one shared adder,
// each axis passing the setup, run and store states (a quantise axis skips the
// run state when clamped, flat or b is 0, b being the axis bits setting), then
// the emit state loads the output register.
// Throughput: one word at a time, set by the bit-serial shared adder; the next
// word is taken the cycle after the result register loads, and a result not
// yet taken holds the sequencer until it is.
// Reset: asynchronous, clears the box to zero and all bits settings to 8.
module bounding_box_coordinate_quantiser_unit #(
	parameter int COORD_WIDTH = bbcq_pkg::COORD_WIDTH_DEF,
	parameter int MAX_BITS    = bbcq_pkg::MAX_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream.
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [95:0]                        s_axis_tdata,  // val_x, val_y, val_z
	input  logic [1:0]                         s_axis_tuser,  // kind
	// Result stream.
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [95:0]                        m_axis_tdata,  // out_x, out_y, out_z
	output logic [2:0]                         m_axis_tuser,  // flat_axes
	// Configuration write port.
	input  logic                               cfg_we,
	input  logic [bbcq_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [bbcq_pkg::BITS_W-1:0]        cfg_data
);
	import bbcq_pkg::*;

	localparam int RW   = (COORD_WIDTH < VAL_W) ? COORD_WIDTH : VAL_W;
	localparam int SW   = (COORD_WIDTH > VAL_W) ? COORD_WIDTH : VAL_W;
	localparam int EBW  = $clog2(MAX_BITS + 1);
	localparam int CNTW = $clog2(MAX_BITS + 2);

	seq_state_t state_q, state_d;

	logic [BITS_W-1:0] bits_q [NUM_AXES];
	kind_t             kind_q;
	logic [VAL_W-1:0]  val_q  [NUM_AXES];
	logic [1:0]        axis_q;
	logic              direct_q;
	logic [VAL_W-1:0]  dres_q;
	logic [VAL_W-1:0]  res_q  [NUM_AXES];
	logic [2:0]        flat_q;
	logic [95:0]       out_data_q;
	logic [2:0]        out_flat_q;
	logic              m_valid_q;

	logic                          in_acc;
	logic                          emit_go;
	logic signed [COORD_WIDTH-1:0] in_coord [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] low      [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] high     [NUM_AXES];

	logic signed [COORD_WIDTH-1:0] c_sel;
	logic signed [COORD_WIDTH-1:0] low_sel;
	logic signed [COORD_WIDTH-1:0] high_sel;
	logic [COORD_WIDTH-1:0]        range_sel;
	logic [EBW-1:0]                b_sel;
	logic [MAX_BITS-1:0]           top_sel;
	logic [MAX_BITS-1:0]           qv;
	logic                          flat_sel;
	logic                          iter;
	logic                          direct_d;
	logic [VAL_W-1:0]              dres_d;
	logic [COORD_WIDTH-1:0]        acc_in;
	logic [MAX_BITS:0]             sh_in;
	logic [CNTW-1:0]               cnt_in;
	logic [SW-1:0]                 rebuilt;
	logic [VAL_W-1:0]              res_d;

	alu_ctl_t               alu_ctl;
	logic                   alu_busy;
	logic [COORD_WIDTH-1:0] alu_acc;
	logic [MAX_BITS:0]      alu_sh;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign emit_go = !m_valid_q || m_axis_tready;

	// Coordinates of the incoming word, wrapped to the coordinate width.
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			in_coord[a] = COORD_WIDTH'($signed(s_axis_tdata[a*VAL_W +: RW]));
		end
	end

	bbcq_box #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_box (
		.clk   (clk),
		.arst_n(arst_n),
		.upd   (in_acc && (s_axis_tuser == KIND_START || s_axis_tuser == KIND_WIDEN)),
		.start (s_axis_tuser == KIND_START),
		.coord (in_coord),
		.low   (low),
		.high  (high)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) bits_q[a] <= BITS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_BITS: bits_q[0] <= cfg_data;
				REG_Y_BITS: bits_q[1] <= cfg_data;
				REG_Z_BITS: bits_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Per-axis operands for the axis being worked on.
	always_comb begin
		c_sel    = COORD_WIDTH'($signed(val_q[axis_q][RW-1:0]));
		low_sel  = low[axis_q];
		high_sel = high[axis_q];
		range_sel = (high_sel > low_sel) ? COORD_WIDTH'(high_sel - low_sel) : '0;
		flat_sel = (range_sel == '0);
		if (bits_q[axis_q] > BITS_W'(MAX_BITS)) b_sel = EBW'(MAX_BITS);
		else b_sel = EBW'(bits_q[axis_q]);
		top_sel = ~({MAX_BITS{1'b1}} << b_sel);
		// Bucket index clamp for dequantise: negative reads as zero.
		if (val_q[axis_q][VAL_W-1]) qv = '0;
		else if (val_q[axis_q] > VAL_W'(top_sel)) qv = top_sel;
		else qv = val_q[axis_q][MAX_BITS-1:0];
	end

	// Setup of the shared unit, or a direct result for clamped points.
	always_comb begin
		direct_d = 1'b0;
		dres_d   = '0;
		iter     = 1'b1;
		acc_in   = '0;
		sh_in    = '0;
		cnt_in   = CNTW'(b_sel);
		unique case (kind_q)
			KIND_QUANT: begin
				acc_in = COORD_WIDTH'(c_sel - low_sel);
				if (flat_sel || c_sel <= low_sel) begin
					direct_d = 1'b1;
					iter     = 1'b0;
				end else if (c_sel >= high_sel) begin
					direct_d = 1'b1;
					dres_d   = VAL_W'(top_sel);
					iter     = 1'b0;
				end
			end
			KIND_DEQUANT: begin
				sh_in  = {qv, 1'b1};
				cnt_in = CNTW'(b_sel) + CNTW'(1);
			end
			default: begin
				iter = 1'b0;
			end
		endcase
	end

	bbcq_alu #(
		.COORD_WIDTH(COORD_WIDTH),
		.MAX_BITS   (MAX_BITS)
	) u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (alu_ctl),
		.range_in(range_sel),
		.acc_in  (acc_in),
		.sh_in   (sh_in),
		.cnt_in  (cnt_in),
		.busy    (alu_busy),
		.acc     (alu_acc),
		.sh      (alu_sh)
	);

	// Result of one axis: quotient, direct value, or minimum plus offset.
	always_comb begin
		rebuilt = SW'(low_sel) + SW'(alu_acc);
		if (kind_q == KIND_DEQUANT) res_d = rebuilt[VAL_W-1:0];
		else if (direct_q) res_d = dres_q;
		else res_d = VAL_W'(alu_sh);
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (s_axis_tuser == KIND_QUANT || s_axis_tuser == KIND_DEQUANT))
					state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (iter && cnt_in != '0) state_d = ST_RUN;
				else state_d = ST_STORE;
			end
			ST_RUN: begin
				if (!alu_busy) state_d = ST_STORE;
			end
			ST_STORE: begin
				if (axis_q == 2'd2) state_d = ST_EMIT;
				else state_d = ST_SETUP;
			end
			ST_EMIT: begin
				if (emit_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_axis_tready    = 1'b0;
		alu_ctl.load     = 1'b0;
		alu_ctl.mode_div = (kind_q == KIND_QUANT);
		unique case (state_q)
			ST_IDLE:  s_axis_tready = 1'b1;
			ST_SETUP: alu_ctl.load  = iter;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Word capture, axis counter and per-axis results.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			kind_q <= kind_t'(s_axis_tuser);
			for (int a = 0; a < NUM_AXES; a++) val_q[a] <= s_axis_tdata[a*VAL_W +: VAL_W];
			axis_q <= 2'd0;
		end
		if (state_q == ST_SETUP) begin
			direct_q       <= direct_d;
			dres_q         <= dres_d;
			flat_q[axis_q] <= flat_sel;
		end
		if (state_q == ST_STORE) begin
			res_q[axis_q] <= res_d;
			axis_q        <= axis_q + 2'd1;
		end
	end

	// Output register, loaded once the previous word has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && emit_go) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && emit_go) begin
			out_data_q <= {res_q[2], res_q[1], res_q[0]};
			out_flat_q <= flat_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_flat_q;

	// The box never inverts on any axis.
	assert property (@(posedge clk) disable iff (!arst_n)
		low[0] <= high[0] && low[1] <= high[1] && low[2] <= high[2])
		else $error("bounding box corners out of order");

	// A bucket index from the divider fits in the axis bits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STORE && kind_q == KIND_QUANT && !direct_q) |->
		((alu_sh >> b_sel) == '0))
		else $error("quantised index exceeds bucket count");

	// Leaving the emit state always presents a result word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && emit_go) |=> m_axis_tvalid)
		else $error("result word lost at emit");

	// The shared unit finishes before its result is stored.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STORE) |-> !alu_busy)
		else $error("store while shared unit busy");

endmodule

// ===== verif/bounding_box_coordinate_quantiser_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bounding_box_coordinate_quantiser_unit: directed and random
// box, quantise and dequantise words, checked against a bit-exact predictor kept in the bench.
// Depends on bbcq_pkg and on the RTL of the block.
module bounding_box_coordinate_quantiser_unit_tb;
	import bbcq_pkg::*;

	localparam int MAX_B        = MAX_BITS_DEF;
	localparam int DRAIN_CYCLES = 3 * (MAX_BITS_DEF + 4) + 40;
	localparam int RANDOM_WORDS = 1550;
	localparam int SEGMENTS     = 8;

	// One input word: kind plus x, y, z with x in the lowest bits.
	typedef struct packed {
		kind_t            kind;
		logic [2:0][31:0] val;
	} box_word_t;

	// One result word: three coordinates or indexes and the flat-axis flags.
	typedef struct packed {
		logic [2:0][31:0] coord;
		logic [2:0]       flat;
	} box_result_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [95:0]          s_axis_tdata  = '0;  // val_x, val_y, val_z
	logic [1:0]           s_axis_tuser  = KIND_START;  // kind
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [95:0]          m_axis_tdata;  // out_x, out_y, out_z
	logic [2:0]           m_axis_tuser;  // flat_axes
	logic                 cfg_we        = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index     = REG_X_BITS;
	logic [BITS_W-1:0]    cfg_data      = '0;

	// Predictor state: the box as the block holds it and the bits settings.
	longint     box_lo [3] = '{0, 0, 0};
	longint     box_hi [3] = '{0, 0, 0};
	logic [4:0] axis_bits [3] = '{BITS_RESET, BITS_RESET, BITS_RESET};

	// Box as seen at generation time, used only to steer the stimulus.
	longint gen_lo [3] = '{0, 0, 0};
	longint gen_hi [3] = '{0, 0, 0};

	box_word_t   pending_words[$];
	box_result_t predicted_results[$];
	box_word_t   cur_word;

	int tx_idle_pct     = 0;
	int rx_idle_pct     = 0;
	int words_queued    = 0;
	int words_accepted  = 0;
	int results_checked = 0;
	int settings_used   = 0;
	int fail_count      = 0;

	string axis_name [3] = '{"out_x", "out_y", "out_z"};

	bounding_box_coordinate_quantiser_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Free-running 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Settings above the limit behave as the limit.
	function automatic int unsigned eff_bits(input logic [4:0] v);
		return (v > MAX_B) ? MAX_B : v;
	endfunction

	// Update the box or compute the result that an accepted word must produce.
	task automatic apply_box_word(input box_word_t w);
		box_result_t r;
		longint      c, lo, hi;
		logic [63:0] span, offs, top, q, res;
		int unsigned b;
		if (w.kind == KIND_START || w.kind == KIND_WIDEN) begin
			for (int d = 0; d < 3; d++) begin
				c = $signed(w.val[d]);
				if (w.kind == KIND_START || c < box_lo[d]) box_lo[d] = c;
				if (w.kind == KIND_START || c > box_hi[d]) box_hi[d] = c;
			end
			return;
		end
		r = '0;
		for (int d = 0; d < 3; d++) begin
			b = eff_bits(axis_bits[d]);
			top = (64'd1 << b) - 64'd1;
			lo = box_lo[d];
			hi = box_hi[d];
			span = (hi > lo) ? 64'(hi - lo) : 64'd0;
			r.flat[d] = (span == 64'd0);
			if (w.kind == KIND_QUANT) begin
				c = $signed(w.val[d]);
				if (span == 64'd0 || c <= lo) begin
					res = 64'd0;
				end else begin
					offs = 64'(c - lo);
					res = (offs >= span) ? top : (offs << b) / span;
				end
			end else begin
				// Negative indexes count as zero, large ones as the top bucket.
				if (w.val[d][31])
					q = 64'd0;
				else
					q = (64'(w.val[d]) > top) ? top : 64'(w.val[d]);
				offs = ((2 * q + 1) * span) >> (b + 1);
				res = 64'(lo) + offs;
			end
			r.coord[d] = res[31:0];
		end
		predicted_results = {predicted_results, r};
	endtask

	task automatic note_mismatch(input string field, input logic [31:0] want, got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: mismatch on %s, expected %h, got %h", $time, field, want, got);
	endtask

	// Compare one result word with the oldest prediction, field by field.
	task automatic check_result(input logic [95:0] data, input logic [2:0] flat);
		box_result_t want;
		results_checked++;
		if (predicted_results.size() == 0) begin
			note_mismatch("result word with nothing pending", '0, data[31:0]);
			return;
		end
		want = predicted_results.pop_front();
		for (int d = 0; d < 3; d++)
			if (data[32*d +: 32] !== want.coord[d])
				note_mismatch(axis_name[d], want.coord[d], data[32*d +: 32]);
		if (flat !== want.flat)
			note_mismatch("flat_axes", 32'(want.flat), 32'(flat));
	endtask

	// Driver: presents queued words, idling at random between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_box_word(cur_word);
				words_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					cur_word = pending_words.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= cur_word.val;
					s_axis_tuser  <= cur_word.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result word and stalls the block at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata, m_axis_tuser);
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Queue one word and track the box it leaves behind.
	task automatic push_word(input kind_t k, input logic [31:0] x, y, z);
		box_word_t w;
		longint    c;
		w.kind = k;
		w.val  = {z, y, x};
		if (k == KIND_START || k == KIND_WIDEN) begin
			for (int d = 0; d < 3; d++) begin
				c = $signed(w.val[d]);
				if (k == KIND_START || c < gen_lo[d]) gen_lo[d] = c;
				if (k == KIND_START || c > gen_hi[d]) gen_hi[d] = c;
			end
		end
		pending_words = {pending_words, w};
		words_queued++;
	endtask

	// Coordinates of every magnitude, with the extremes mixed in.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($urandom_range(0, 2000)) - 32'd1000;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return $signed($urandom) >>> $urandom_range(0, 31);
		endcase
	endfunction

	// A point to quantise: inside, on the corners, just outside or anywhere.
	function automatic logic [31:0] quant_coord(input int d);
		logic [63:0] span, r;
		span = (gen_hi[d] > gen_lo[d]) ? 64'(gen_hi[d] - gen_lo[d]) : 64'd0;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: return gen_lo[d][31:0];
			1: return gen_hi[d][31:0];
			2: return gen_lo[d][31:0] - 32'($urandom_range(1, 1000));
			3: return gen_hi[d][31:0] + 32'($urandom_range(1, 1000));
			4: return rand_coord();
			default: return (span == 64'd0) ? gen_lo[d][31:0] :
				32'(gen_lo[d] + longint'(r % span));
		endcase
	endfunction

	// A bucket index to rebuild: mostly legal, sometimes negative or too large.
	function automatic logic [31:0] dequant_index(input int d);
		logic [31:0] top;
		top = (32'd1 << eff_bits(axis_bits[d])) - 32'd1;
		case ($urandom_range(0, 7))
			0: return top;
			1: return top + 32'd1;
			2: return $urandom;
			3: return 32'h8000_0000 | $urandom;
			default: return $urandom_range(0, top);
		endcase
	endfunction

	// Mostly a fresh box followed by queries; sometimes queries on the old box or noise.
	task automatic box_sequence();
		logic [31:0]        p [3];
		logic signed [31:0] delta;
		int                 n;
		if ($urandom_range(0, 9) < 8) begin
			for (int d = 0; d < 3; d++) p[d] = rand_coord();
			push_word(KIND_START, p[0], p[1], p[2]);
			n = $urandom_range(0, 3);
			repeat (n) begin
				for (int d = 0; d < 3; d++) begin
					delta = $signed($urandom) >>> $urandom_range(8, 31);
					p[d] = $urandom_range(0, 1) ? rand_coord() : p[d] + delta;
				end
				push_word(KIND_WIDEN, p[0], p[1], p[2]);
			end
		end
		n = $urandom_range(2, 8);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				push_word(kind_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
			else if ($urandom_range(0, 1))
				push_word(KIND_QUANT, quant_coord(0), quant_coord(1), quant_coord(2));
			else
				push_word(KIND_DEQUANT, dequant_index(0), dequant_index(1), dequant_index(2));
		end
	endtask

	// Wait until every word is taken and every result is back, then let the block settle.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_words.size() != 0 || s_axis_tvalid || predicted_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write all three bits settings while the block is idle.
	task automatic write_bits(input logic [4:0] bx, by, bz);
		wait_idle();
		axis_bits[0] = bx;
		axis_bits[1] = by;
		axis_bits[2] = bz;
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_X_BITS;
		cfg_data  <= bx;
		@(posedge clk);
		cfg_index <= REG_Y_BITS;
		cfg_data  <= by;
		@(posedge clk);
		cfg_index <= REG_Z_BITS;
		cfg_data  <= bz;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [4:0] small_bits();
		return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
			5'($urandom_range(0, 10));
	endfunction

	// Stimulus sequence and end of run.
	initial begin
		int target;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 17;
		rx_idle_pct = 63;

		// Reset box is flat on every axis; bits settings are at their reset value.
		push_word(KIND_QUANT, 32'd5, -32'sd5, 32'd0);
		push_word(KIND_DEQUANT, 32'd0, 32'd255, 32'hffff_ffff);
		// Widest possible box, queried at the extremes.
		push_word(KIND_START, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_word(KIND_WIDEN, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		push_word(KIND_QUANT, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
		push_word(KIND_QUANT, 32'hffff_ffff, 32'h7fff_fffe, 32'h8000_0001);
		push_word(KIND_DEQUANT, 32'd0, 32'd255, 32'h8000_0000);
		push_word(KIND_DEQUANT, 32'h7fff_ffff, 32'd256, 32'd128);
		// Small box with flat axes, points outside on both sides.
		push_word(KIND_START, 32'd100, -32'sd50, 32'd7);
		push_word(KIND_WIDEN, 32'd100, 32'd50, 32'd7);
		push_word(KIND_QUANT, 32'd100, 32'd0, 32'd8);
		push_word(KIND_QUANT, 32'd99, -32'sd51, 32'd6);
		push_word(KIND_DEQUANT, 32'd3, 32'd255, 32'd1);
		push_word(KIND_WIDEN, -32'sd100, 32'd60, 32'd7);
		push_word(KIND_WIDEN, 32'd0, 32'd0, 32'd0);
		push_word(KIND_QUANT, 32'd101, 32'd61, 32'd8);
		push_word(KIND_QUANT, -32'sd101, 32'd59, 32'd3);
		// Zero bits, the limit, and a setting above the limit.
		write_bits(5'd0, 5'd24, 5'd31);
		push_word(KIND_QUANT, 32'd50, 32'd30, 32'd3);
		push_word(KIND_DEQUANT, 32'd0, 32'h00ff_ffff, 32'd5);
		push_word(KIND_DEQUANT, 32'd1, 32'h0100_0000, 32'd0);
		write_bits(5'd24, 5'd0, 5'd25);
		push_word(KIND_START, 32'h8000_0000, 32'd0, 32'hffff_ffff);
		push_word(KIND_WIDEN, 32'h7fff_ffff, 32'd1, 32'd0);
		push_word(KIND_QUANT, 32'd0, 32'd1, 32'hffff_ffff);
		push_word(KIND_DEQUANT, 32'h00ff_ffff, 32'd0, 32'h7fff_ffff);

		// Random segments, each under its own bits settings and idle pattern.
		for (int s = 0; s < SEGMENTS; s++) begin
			case (s)
				1: write_bits(5'd24, 5'd24, 5'd24);
				2: write_bits(5'd0, 5'd0, 5'd0);
				3: write_bits(5'd31, 5'd30, 5'd25);
				default: write_bits(small_bits(), small_bits(), small_bits());
			endcase
			if (s < 3) begin
				tx_idle_pct = 17;
				rx_idle_pct = 63;
			end else if (s < 6) begin
				tx_idle_pct = 63;
				rx_idle_pct = 17;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			target = words_queued + RANDOM_WORDS / SEGMENTS;
			while (words_queued < target) box_sequence();
		end

		wait_idle();
		fail_count += predicted_results.size();
		$display("Sent %0d words and checked %0d result words under %0d bits settings,",
			words_accepted, results_checked, settings_used + 1);
		$display("with sender and receiver idling in turn and in full-rate stretches.");
		if (fail_count == 0) begin
			$display("bounding_box_coordinate_quantiser_unit verification clean");
		end else begin
			$display("bounding_box_coordinate_quantiser_unit verification failed");
		end
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#20_000_000;
		$display("bounding_box_coordinate_quantiser_unit verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/bbcq_pkg.sv
hw/rtl/bbcq_box.sv
hw/rtl/bbcq_alu.sv
hw/rtl/bounding_box_coordinate_quantiser_unit.sv
verif/bounding_box_coordinate_quantiser_unit_tb.sv
